### rtl/dcgas_pkg.sv
// ----------------------------------------------------------------------------
// dcgas_pkg: shared types and constants of the dual-chip glcd sequencer
// opcodes, result kinds, controller command bytes and the job record that
// travels from the request decoder to the transaction expander
// ----------------------------------------------------------------------------
package dcgas_pkg;

  // display geometry
  localparam int COLUMNS_PER_CHIP = 64;
  localparam int PAGE_COUNT       = 8;

  // controller command bytes
  localparam logic [7:0] CMD_Y     = 8'h40;
  localparam logic [7:0] CMD_START = 8'hC0;
  localparam logic [7:0] CMD_X     = 8'hB8;
  localparam logic [7:0] CMD_ON    = 8'h3E;
  localparam logic [7:0] BYTE_ALL  = 8'hFF;

  // request opcodes
  localparam logic [2:0] OP_WRITE  = 3'd0;
  localparam logic [2:0] OP_READ   = 3'd1;
  localparam logic [2:0] OP_SET    = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_START  = 3'd4;
  localparam logic [2:0] OP_ON     = 3'd5;
  localparam logic [2:0] OP_RETURN = 3'd6;

  // result kinds
  localparam logic [1:0] KIND_BUS    = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // operation held across a read sequence
  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_READ  = 2'd1,
    PEND_SET   = 2'd2,
    PEND_CLEAR = 2'd3
  } pend_t;

  // work items handed to the expander
  typedef enum logic [2:0] {
    JOB_ADDR_WRITE = 3'd0,  // four address commands, then a data write
    JOB_ADDR_READ  = 3'd1,  // four address commands, then a data read
    JOB_BOTH       = 3'd2,  // one command byte to each chip
    JOB_RESULT     = 3'd3,  // read value handed back
    JOB_REJECT     = 3'd4   // request in the wrong phase or with an unused opcode
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [2:0]  page;
    logic [6:0]  column;
    logic [7:0]  data;
  } job_t;

endpackage

### rtl/dcgas_front.sv
// ----------------------------------------------------------------------------
// dcgas_front: request decoder
// tracks the read phase, holds the address of a pending read and turns each
// accepted request into one job record
// ----------------------------------------------------------------------------
module dcgas_front
  import dcgas_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       req_fire,
  input  logic [2:0] opcode,
  input  logic [5:0] row,
  input  logic [6:0] column,
  input  logic [7:0] data_byte,
  output job_t       job
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_DUMMY = 3'b010,
    PH_DATA  = 3'b100
  } phase_t;

  phase_t     phase_r, phase_nxt;
  pend_t      pend_r, pend_nxt;
  logic [2:0] held_page_r, held_page_nxt;
  logic [6:0] held_col_r, held_col_nxt;
  logic [2:0] held_bit_r, held_bit_nxt;

  logic [2:0] byte_page;
  logic [2:0] dot_page;
  logic [7:0] mask;

  // page of a byte request and of a dot request
  assign byte_page = 3'(row % 6'(PAGE_COUNT));
  assign dot_page  = 3'((row >> 3) % 6'(PAGE_COUNT));
  assign mask      = 8'd1 << held_bit_r;

  // classify the request against the current phase
  always_comb begin
    phase_nxt     = phase_r;
    pend_nxt      = pend_r;
    held_page_nxt = held_page_r;
    held_col_nxt  = held_col_r;
    held_bit_nxt  = held_bit_r;
    job.kind      = JOB_REJECT;
    job.page      = held_page_r;
    job.column    = held_col_r;
    job.data      = 8'd0;
    case (phase_r)
      PH_IDLE: begin
        case (opcode)
          OP_WRITE: begin
            job.kind   = JOB_ADDR_WRITE;
            job.page   = byte_page;
            job.column = column;
            job.data   = data_byte;
          end
          OP_READ, OP_SET, OP_CLEAR: begin
            if (opcode == OP_READ) begin
              held_page_nxt = byte_page;
              held_bit_nxt  = 3'd0;
            end else begin
              held_page_nxt = dot_page;
              held_bit_nxt  = row[2:0];
            end
            held_col_nxt = column;
            pend_nxt     = pend_t'(opcode[1:0]);
            phase_nxt    = PH_DUMMY;
            job.kind     = JOB_ADDR_READ;
            job.page     = held_page_nxt;
            job.column   = column;
          end
          OP_START: begin
            job.kind = JOB_BOTH;
            job.data = CMD_START | {2'b00, row};
          end
          OP_ON: begin
            job.kind = JOB_BOTH;
            job.data = CMD_ON | 8'd1;
          end
          default: job.kind = JOB_REJECT;
        endcase
      end
      PH_DUMMY: begin
        if (opcode == OP_RETURN) begin
          job.kind  = JOB_ADDR_READ;
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (opcode == OP_RETURN) begin
          phase_nxt = PH_IDLE;
          if (pend_r == PEND_READ) begin
            job.kind = JOB_RESULT;
            job.data = data_byte;
          end else begin
            job.kind = JOB_ADDR_WRITE;
            job.data = (pend_r == PEND_SET) ? (data_byte | mask)
                                            : (data_byte & (BYTE_ALL ^ mask));
          end
        end
      end
      default: job.kind = JOB_REJECT;
    endcase
  end

  // phase and held address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pend_r      <= PEND_NONE;
      held_page_r <= 3'd0;
      held_col_r  <= 7'd0;
      held_bit_r  <= 3'd0;
    end else if (req_fire) begin
      phase_r     <= phase_nxt;
      pend_r      <= pend_nxt;
      held_page_r <= held_page_nxt;
      held_col_r  <= held_col_nxt;
      held_bit_r  <= held_bit_nxt;
    end
  end

endmodule

### rtl/dcgas_queue.sv
// ----------------------------------------------------------------------------
// dcgas_queue: two-entry job queue
// decouples the request decoder from the transaction expander
// ----------------------------------------------------------------------------
module dcgas_queue
  import dcgas_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  job_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = slot_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### rtl/dcgas_back.sv
// ----------------------------------------------------------------------------
// dcgas_back: transaction expander
// walks the head job, when out_ready and the queue allow, one bus transaction per cycle into the output register
// ----------------------------------------------------------------------------
module dcgas_back
  import dcgas_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       empty,
  input  job_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic       out_chip,
  output logic       out_is_data,
  output logic       out_is_read,
  output logic [7:0] out_bus_byte,
  output logic       out_last
);

  localparam logic [7:0] COL_SPLIT = 8'(COLUMNS_PER_CHIP);
  localparam logic [5:0] LEFT_PARK = 6'(COLUMNS_PER_CHIP - 1);

  logic [2:0] step_r;
  logic       out_valid_r;
  logic [1:0] kind_r;
  logic       chip_r, is_data_r, is_read_r, last_r;
  logic [7:0] byte_r;

  logic       advance;
  logic       right;
  logic [5:0] y0, y1;
  logic [1:0] kind_nxt;
  logic       chip_nxt, is_data_nxt, is_read_nxt, last_nxt;
  logic [7:0] byte_nxt;

  assign advance = !empty && (!out_valid_r || out_ready);
  assign pop     = advance && last_nxt;

  // split column address of both chips
  assign right = ({1'b0, head.column} >= COL_SPLIT);
  assign y0    = right ? LEFT_PARK : head.column[5:0];
  assign y1    = right ? 6'({1'b0, head.column} - COL_SPLIT) : 6'd0;

  // transaction for the current step
  always_comb begin
    kind_nxt    = KIND_BUS;
    chip_nxt    = 1'b0;
    is_data_nxt = 1'b0;
    is_read_nxt = 1'b0;
    byte_nxt    = 8'd0;
    last_nxt    = 1'b0;
    case (head.kind)
      JOB_ADDR_WRITE, JOB_ADDR_READ: begin
        case (step_r)
          3'd0: byte_nxt = CMD_X | {5'd0, head.page};
          3'd1: begin
            chip_nxt = 1'b1;
            byte_nxt = CMD_X | {5'd0, head.page};
          end
          3'd2: byte_nxt = CMD_Y | {2'b00, y0};
          3'd3: begin
            chip_nxt = 1'b1;
            byte_nxt = CMD_Y | {2'b00, y1};
          end
          default: begin
            chip_nxt    = right;
            is_data_nxt = 1'b1;
            is_read_nxt = (head.kind == JOB_ADDR_READ);
            byte_nxt    = (head.kind == JOB_ADDR_READ) ? 8'd0 : head.data;
            last_nxt    = 1'b1;
          end
        endcase
      end
      JOB_BOTH: begin
        byte_nxt = head.data;
        chip_nxt = (step_r != 3'd0);
        last_nxt = (step_r != 3'd0);
      end
      JOB_RESULT: begin
        kind_nxt = KIND_READ;
        byte_nxt = head.data;
        last_nxt = 1'b1;
      end
      default: begin
        kind_nxt = KIND_REJECT;
        last_nxt = 1'b1;
      end
    endcase
  end

  // step counter within the head job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 3'd0;
    end else if (advance) begin
      step_r <= last_nxt ? 3'd0 : step_r + 3'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind_r    <= kind_nxt;
      chip_r    <= chip_nxt;
      is_data_r <= is_data_nxt;
      is_read_r <= is_read_nxt;
      byte_r    <= byte_nxt;
      last_r    <= last_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = kind_r;
  assign out_chip     = chip_r;
  assign out_is_data  = is_data_r;
  assign out_is_read  = is_read_r;
  assign out_bus_byte = byte_r;
  assign out_last     = last_r;

endmodule

### rtl/dual_chip_glcd_access_sequencer.sv
// ----------------------------------------------------------------------------
// dual_chip_glcd_access_sequencer: request sequencer for a two-controller
// 128x64 graphic lcd
//
// requests (write byte, read byte, set dot, clear dot, start line, display on,
// read return) come in on the in_ channel; bus transactions, read results and
// rejects leave on the out_ channel, one transfer per cycle unless stalled by
// out_ready or an empty queue; out_last marks each request's final transfer.
// a request is decoded in the cycle it is accepted and queued as one job; the
// expander takes it from the queue head into the output register, and a
// request gives 1 to 5 transfers (five for data accesses), set by the
// expander step counter.
// a two-entry job queue sits between decoder and expander, so requests keep
// being accepted while the output register waits on out_ready; when the
// queue fills, in_ready drops until the expander frees an entry.
// read returns must be sent back as opcode 6 requests; set and clear dot take
// three requests in total (the dot request and two read returns).
// reset clears the read phase, the held address, the queue and the output.
// ----------------------------------------------------------------------------
module dual_chip_glcd_access_sequencer
  import dcgas_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_opcode,
  input  logic [5:0] in_row,
  input  logic [6:0] in_column,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic       out_chip,
  output logic       out_is_data,
  output logic       out_is_read,
  output logic [7:0] out_bus_byte,
  output logic       out_last
);

  logic req_fire;
  logic full, empty, pop;
  job_t new_job, head;

  assign in_ready = !full;
  assign req_fire = in_valid && in_ready;

  // request decoder
  dcgas_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_fire  (req_fire),
    .opcode    (in_opcode),
    .row       (in_row),
    .column    (in_column),
    .data_byte (in_data_byte),
    .job       (new_job)
  );

  // job queue
  dcgas_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (req_fire),
    .push_job (new_job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  // transaction expander
  dcgas_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_chip     (out_chip),
    .out_is_data  (out_is_data),
    .out_is_read  (out_is_read),
    .out_bus_byte (out_bus_byte),
    .out_last     (out_last)
  );

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the dual-chip glcd access sequencer
// a directed pass covers the field extremes, every request type, rejects while
// idle and while a read is pending, and dot updates on the right chip. A random
// pass follows, mostly complete read, set and clear sequences with random
// content, some broken by stray requests. Both channels idle at random, and an
// in-bench model of the sequencer predicts every transfer on the out_ channel.
// ----------------------------------------------------------------------------
module testbench;
  import dcgas_pkg::*;

  localparam int         CLK_PERIOD   = 4;
  localparam int         ITEM_TARGET  = 430;
  localparam int         DRAIN_CYCLES = 16;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam logic [2:0] OP_ILLEGAL   = 3'd7;

  // read sequence progress as seen by the bench
  typedef enum logic [1:0] {
    AWAIT_NONE  = 2'd0,
    AWAIT_DUMMY = 2'd1,
    AWAIT_DATA  = 2'd2
  } read_phase_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [5:0] row;
    logic [6:0] column;
    logic [7:0] data_byte;
  } lcd_request_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       chip;
    logic       is_data;
    logic       is_read;
    logic [7:0] bus_byte;
    logic       last;
  } lcd_xfer_t;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_ready;
  logic [2:0] in_opcode    = '0;
  logic [5:0] in_row       = '0;
  logic [6:0] in_column    = '0;
  logic [7:0] in_data_byte = '0;
  logic       out_valid;
  logic       out_ready    = 1'b0;
  logic [1:0] out_kind;
  logic       out_chip;
  logic       out_is_data;
  logic       out_is_read;
  logic [7:0] out_bus_byte;
  logic       out_last;

  lcd_request_t request_q[$];
  lcd_xfer_t    expected_q[$];

  // bench copy of the sequencer state
  read_phase_t read_phase  = AWAIT_NONE;
  pend_t       held_op     = PEND_NONE;
  logic [2:0]  held_page   = '0;
  logic [6:0]  held_column = '0;
  logic [2:0]  held_bit    = '0;

  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  bit   in_quiet  = 1'b0;
  bit   out_quiet = 1'b0;
  int   in_gap    = 0;
  int   out_stall = 0;

  int cycle_count       = 0;
  int error_count       = 0;
  int requests_total    = 0;
  int requests_accepted = 0;
  int transfers_checked = 0;
  int read_results      = 0;
  int reject_results    = 0;

  dual_chip_glcd_access_sequencer DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_row       (in_row),
    .in_column    (in_column),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_chip     (out_chip),
    .out_is_data  (out_is_data),
    .out_is_read  (out_is_read),
    .out_bus_byte (out_bus_byte),
    .out_last     (out_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // ---------------------------------------------------------------------------
  // sequencer prediction
  // ---------------------------------------------------------------------------
  task automatic push_xfer(input logic [1:0] kind, input logic chip, input logic is_data,
                           input logic is_read, input logic [7:0] bus_byte);
    lcd_xfer_t x;
    x.kind     = kind;
    x.chip     = chip;
    x.is_data  = is_data;
    x.is_read  = is_read;
    x.bus_byte = bus_byte;
    x.last     = 1'b0;
    expected_q.push_back(x);
  endtask

  // page to both chips, then the split column address, left chip first
  task automatic push_address(input logic [2:0] page, input logic [6:0] col);
    logic [6:0] left_y;
    logic [6:0] right_y;
    if (col < COLUMNS_PER_CHIP) begin
      left_y  = col;
      right_y = '0;
    end else begin
      left_y  = 7'(COLUMNS_PER_CHIP - 1);
      right_y = 7'(col - COLUMNS_PER_CHIP);
    end
    push_xfer(KIND_BUS, 1'b0, 1'b0, 1'b0, CMD_X | {5'd0, page});
    push_xfer(KIND_BUS, 1'b1, 1'b0, 1'b0, CMD_X | {5'd0, page});
    push_xfer(KIND_BUS, 1'b0, 1'b0, 1'b0, CMD_Y | {2'd0, left_y[5:0]});
    push_xfer(KIND_BUS, 1'b1, 1'b0, 1'b0, CMD_Y | {2'd0, right_y[5:0]});
  endtask

  task automatic predict_transfers(input logic [2:0] op, input logic [5:0] row,
                                   input logic [6:0] col, input logic [7:0] data);
    logic [7:0] mask;
    logic [7:0] new_byte;
    logic [2:0] page;
    lcd_xfer_t  tail;
    if (read_phase == AWAIT_NONE) begin
      case (op)
        OP_WRITE: begin
          page = 3'(row % PAGE_COUNT);
          push_address(page, col);
          push_xfer(KIND_BUS, col >= COLUMNS_PER_CHIP, 1'b1, 1'b0, data);
        end
        OP_READ, OP_SET, OP_CLEAR: begin
          if (op == OP_READ) begin
            held_page = 3'(row % PAGE_COUNT);
            held_bit  = '0;
            held_op   = PEND_READ;
          end else begin
            held_page = 3'((row >> 3) % PAGE_COUNT);
            held_bit  = row[2:0];
            held_op   = (op == OP_SET) ? PEND_SET : PEND_CLEAR;
          end
          held_column = col;
          push_address(held_page, held_column);
          push_xfer(KIND_BUS, held_column >= COLUMNS_PER_CHIP, 1'b1, 1'b1, 8'h00);
          read_phase = AWAIT_DUMMY;
        end
        OP_START: begin
          push_xfer(KIND_BUS, 1'b0, 1'b0, 1'b0, CMD_START | {2'd0, row});
          push_xfer(KIND_BUS, 1'b1, 1'b0, 1'b0, CMD_START | {2'd0, row});
        end
        OP_ON: begin
          push_xfer(KIND_BUS, 1'b0, 1'b0, 1'b0, CMD_ON | 8'h01);
          push_xfer(KIND_BUS, 1'b1, 1'b0, 1'b0, CMD_ON | 8'h01);
        end
        default: push_xfer(KIND_REJECT, 1'b0, 1'b0, 1'b0, 8'h00);
      endcase
    end else if (op == OP_RETURN && read_phase == AWAIT_DUMMY) begin
      // dummy read came back: re-address and read for real
      push_address(held_page, held_column);
      push_xfer(KIND_BUS, held_column >= COLUMNS_PER_CHIP, 1'b1, 1'b1, 8'h00);
      read_phase = AWAIT_DATA;
    end else if (op == OP_RETURN && read_phase == AWAIT_DATA) begin
      if (held_op == PEND_READ) begin
        push_xfer(KIND_READ, 1'b0, 1'b0, 1'b0, data);
      end else begin
        // read-modify-write of one dot
        mask     = 8'd1 << held_bit;
        new_byte = (held_op == PEND_SET) ? (data | mask) : (data & ~mask);
        push_address(held_page, held_column);
        push_xfer(KIND_BUS, held_column >= COLUMNS_PER_CHIP, 1'b1, 1'b0, new_byte);
      end
      read_phase = AWAIT_NONE;
    end else begin
      push_xfer(KIND_REJECT, 1'b0, 1'b0, 1'b0, 8'h00);
    end
    // flag the final transfer of this request
    tail      = expected_q.pop_back();
    tail.last = 1'b1;
    expected_q.push_back(tail);
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  task automatic check_transfer();
    lcd_xfer_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected transfer: kind %0d, bus_byte %0h", out_kind, out_bus_byte);
      error_count++;
    end else begin
      want = expected_q.pop_front();
      compare_field("kind", 8'(want.kind), 8'(out_kind));
      compare_field("chip", 8'(want.chip), 8'(out_chip));
      compare_field("is_data", 8'(want.is_data), 8'(out_is_data));
      compare_field("is_read", 8'(want.is_read), 8'(out_is_read));
      compare_field("bus_byte", want.bus_byte, out_bus_byte);
      compare_field("last", 8'(want.last), 8'(out_last));
      transfers_checked++;
      if (want.kind == KIND_READ) read_results++;
      if (want.kind == KIND_REJECT) reject_results++;
    end
  endtask

  // sample both handshakes at the rising edge, predict before checking
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_valid && in_ready;
      out_taken <= out_valid && out_ready;
      if (in_valid && in_ready) begin
        predict_transfers(in_opcode, in_row, in_column, in_data_byte);
        requests_accepted++;
      end
      if (out_valid && out_ready) check_transfer();
    end
  end

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_requests
    lcd_request_t req;
    logic         hold;
    if (rst_n) begin
      hold = in_valid;
      if (in_taken) begin
        hold = 1'b0;
        if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
        in_gap = in_quiet ? 0 : $urandom_range(0, 3);
      end else if (!hold && in_gap != 0) begin
        in_gap--;
      end
      if (!hold && in_gap == 0 && request_q.size() != 0) begin
        req          = request_q.pop_front();
        in_opcode    <= req.opcode;
        in_row       <= req.row;
        in_column    <= req.column;
        in_data_byte <= req.data_byte;
        hold         = 1'b1;
      end
      in_valid <= hold;
    end
  end

  // ---------------------------------------------------------------------------
  // result side stalls
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
        out_stall = out_quiet ? 0 : $urandom_range(0, 3);
      end else if (out_stall != 0) begin
        out_stall--;
      end
      out_ready <= (out_stall == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_request(input logic [2:0] op, input logic [5:0] row,
                               input logic [6:0] col, input logic [7:0] data);
    lcd_request_t r;
    r.opcode    = op;
    r.row       = row;
    r.column    = col;
    r.data_byte = data;
    request_q.push_back(r);
  endtask

  // random row, column and byte around a given opcode
  task automatic queue_random(input logic [2:0] op);
    queue_request(op, 6'($urandom_range(0, 63)), 7'($urandom_range(0, 127)),
                  8'($urandom_range(0, 255)));
  endtask

  // stray request that is not a read return; the block rejects it mid-read
  task automatic queue_stray();
    logic [2:0] op;
    op = 3'($urandom_range(0, 6));
    if (op == OP_RETURN) op = OP_ILLEGAL;
    queue_random(op);
  endtask

  initial begin
    int         pick;
    int         strays;
    logic [2:0] op;

    // directed: byte writes at the column and page extremes
    queue_request(OP_WRITE, 6'd0, 7'd0, 8'h00);
    queue_request(OP_WRITE, 6'd63, 7'd127, 8'hFF);
    queue_request(OP_WRITE, 6'd5, 7'd63, 8'hA5);
    queue_request(OP_WRITE, 6'd10, 7'd64, 8'h5A);
    // read byte on the right chip
    queue_request(OP_READ, 6'd7, 7'd100, 8'h00);
    queue_request(OP_RETURN, 6'd0, 7'd0, 8'h00);
    queue_request(OP_RETURN, 6'd0, 7'd0, 8'hC3);
    // set the top dot with rejects in both wait phases
    queue_request(OP_SET, 6'd63, 7'd64, 8'h00);
    queue_request(OP_WRITE, 6'd1, 7'd1, 8'h11);
    queue_request(OP_RETURN, 6'd0, 7'd0, 8'h11);
    queue_request(OP_ILLEGAL, 6'd63, 7'd127, 8'hFF);
    queue_request(OP_RETURN, 6'd0, 7'd0, 8'h00);
    // clear the bottom dot at the last column
    queue_request(OP_CLEAR, 6'd0, 7'd127, 8'h00);
    queue_request(OP_RETURN, 6'd63, 7'd127, 8'hFF);
    queue_request(OP_RETURN, 6'd63, 7'd127, 8'hFF);
    // start line extremes and display on
    queue_request(OP_START, 6'd0, 7'd0, 8'h00);
    queue_request(OP_START, 6'd63, 7'd127, 8'hFF);
    queue_request(OP_ON, 6'd0, 7'd0, 8'h00);
    // read return while idle and the unused opcode
    queue_request(OP_RETURN, 6'd21, 7'd42, 8'h99);
    queue_request(OP_ILLEGAL, 6'd0, 7'd0, 8'h00);

    // random: mostly complete sequences, some broken, some noise
    while (request_q.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        queue_random(OP_WRITE);
      end else if (pick < 56) begin
        op = 3'($urandom_range(1, 3));
        strays = (pick >= 48) ? $urandom_range(1, 2) : 0;
        queue_random(op);
        if (strays != 0 && $urandom_range(0, 1) == 0) begin
          queue_stray();
          strays--;
        end
        queue_random(OP_RETURN);
        while (strays != 0) begin
          queue_stray();
          strays--;
        end
        queue_random(OP_RETURN);
      end else if (pick < 68) begin
        queue_random(OP_START);
      end else if (pick < 76) begin
        queue_random(OP_ON);
      end else if (pick < 86) begin
        op = $urandom_range(0, 1) ? OP_RETURN : OP_ILLEGAL;
        queue_random(op);
      end else begin
        // any opcode; a read-type request gets its returns so the sequence ends idle
        op = 3'($urandom_range(0, 7));
        queue_random(op);
        if (op == OP_READ || op == OP_SET || op == OP_CLEAR) begin
          queue_random(OP_RETURN);
          queue_random(OP_RETURN);
        end
      end
    end
    requests_total = request_q.size();

    // reset, then let the driver run
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for every request to go in and every transfer to come out
    while (requests_accepted != requests_total || expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d requests sent, %0d transfers checked", requests_total, transfers_checked);
    $display("%0d read results and %0d rejects among them", read_results, reject_results);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run time limit
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d transfers outstanding", cycle_count,
             expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
